// ===== hw/rtl/led_strip_pulse_timer_assert.svh =====
// Assertion macros used by the checker of the LED strip pulse timer.
`ifndef LED_STRIP_PULSE_TIMER_ASSERT_SVH
`define LED_STRIP_PULSE_TIMER_ASSERT_SVH

// Same-cycle implication, clocked on clock and disabled while reset is high.
`define LSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled while reset is high.
`define LSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lsp_pkg.sv =====
// Types, constants and a helper function shared by the LED strip pulse timer.
`timescale 1ns / 1ps

package lsp_pkg;

   localparam int NUM_LEDS   = 16;
   localparam int SINE_BITS  = 12;
   localparam int LED_IDX_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   localparam int PHASE_W    = 17;
   localparam int PHASE_WRAP = 108000;
   localparam int RATE_W     = 2;
   localparam int NUM_RATES  = 1 << RATE_W;
   localparam int ARG_W      = PHASE_W + NUM_RATES - 1;
   localparam int SCALE_W    = SINE_BITS + 1;

   localparam logic [31:0] HALF_TURN_PER_STEP = 32'd13671306;
   localparam logic [31:0] PI_Q30             = 32'd3373259426;
   localparam logic [31:0] ONE_Q30            = 32'h4000_0000;
   localparam logic [31:0] FOLD_POINT         = 32'h8000_0000;

   localparam int TERM_W     = 2;
   localparam int DIV_W      = 7;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CYCLES = 32 / DIV_STEPS;
   localparam int DCNT_W     = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_SET   = 1'b0,
      CMD_FRAME = 1'b1
   } command_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Classified command: span carries the hold time of a set or the elapsed
   // time of a frame.
   typedef struct packed {
      command_type           kind;
      logic [LED_IDX_W-1:0]  index;
      pixel_type             colour;
      logic                  pulse;
      logic [RATE_W-1:0]     rate;
      logic [31:0]           span;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } queue_wr_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_rd_type;

   typedef struct packed {
      logic             start;
      logic [ARG_W-1:0] arg;
   } sine_req_type;

   typedef struct packed {
      logic                 done;
      logic [SINE_BITS-1:0] mag;
   } sine_rsp_type;

   // Divisors of the Taylor series terms, innermost term first.
   function automatic logic [DIV_W-1:0] term_divisor(input logic [TERM_W-1:0] term);
      logic [DIV_W-1:0] d;
      unique case (term)
         2'd0: d = 7'd72;
         2'd1: d = 7'd42;
         2'd2: d = 7'd20;
         2'd3: d = 7'd6;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/lsp_front.sv =====
// Front end: takes commands, classifies them and hands them to the queue.
`timescale 1ns / 1ps

module lsp_front import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_command,
   input  logic [5:0]   req_led_index,
   input  pixel_type    req_colour,
   input  logic [7:0]   req_mode,
   input  logic [31:0]  req_hold_ms,
   input  logic [15:0]  req_elapsed_ms,
   input  logic         queue_full,
   output queue_wr_type queue_wr
);

   logic        hold_valid_ff;
   cmd_type     hold_cmd_ff;
   cmd_type     cmd_in;
   command_type kind;
   logic        keep;
   logic        accept;
   logic        push;

   always_comb begin
      kind          = command_type'(req_command);
      cmd_in.kind   = kind;
      cmd_in.index  = req_led_index[LED_IDX_W-1:0];
      cmd_in.colour = req_colour;
      cmd_in.pulse  = (req_mode >= 8'd2) && (req_mode <= 8'd5);
      cmd_in.rate   = RATE_W'(req_mode - 8'd2);
      cmd_in.span   = (kind == CMD_FRAME) ? {16'd0, req_elapsed_ms} : req_hold_ms;
      // A set aimed past the end of the table is dropped here.
      keep = (kind == CMD_FRAME) || ({1'b0, req_led_index} < 7'(NUM_LEDS));
   end

   assign push       = hold_valid_ff && !queue_full;
   assign req_tready = !hold_valid_ff || push;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (accept) begin
         hold_valid_ff <= keep;
      end else if (push) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_cmd_ff <= cmd_in;
      end
   end

   assign queue_wr.push = push;
   assign queue_wr.cmd  = hold_cmd_ff;

endmodule

// ===== hw/rtl/lsp_queue.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module lsp_queue import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type queue_wr,
   output logic         queue_full,
   input  logic         queue_pop,
   output queue_rd_type queue_rd
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign queue_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push        = queue_wr.push && !queue_full;
   assign do_pop         = queue_pop && (count_ff != '0);
   assign queue_rd.valid = (count_ff != '0);
   assign queue_rd.cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.cmd;
      end
   end

endmodule

// ===== hw/rtl/lsp_sine.sv =====
// Sine magnitude unit: fixed-point Taylor series on one shared multiplier.
`timescale 1ns / 1ps

module lsp_sine import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sine_req_type sine_req,
   output sine_rsp_type sine_rsp
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_F,
      S_FOLD,
      S_MUL_X,
      S_MUL_X2,
      S_DIV_LOAD,
      S_DIV,
      S_SUB,
      S_MUL_T,
      S_FINISH
   } sine_state_type;

   sine_state_type       state_ff;
   logic [ARG_W-1:0]     arg_ff;
   logic [63:0]          prod_ff;
   logic [31:0]          g_ff;
   logic [31:0]          x_ff;
   logic [31:0]          x2_ff;
   logic [30:0]          t_ff;
   logic [31:0]          dq_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DCNT_W-1:0]    cnt_ff;
   logic [TERM_W-1:0]    term_ff;
   logic [SINE_BITS-1:0] mag_ff;
   logic                 done_ff;

   logic [31:0]          op_a;
   logic [31:0]          op_b;
   logic [63:0]          prod_in;
   logic                 mul_en;
   logic [31:0]          g_in;
   logic [31:0]          dq_in;
   logic [DIV_W-1:0]     rem_in;
   logic [DIV_W-1:0]     divisor;
   logic [31:0]          r_val;
   logic [SINE_BITS-1:0] mag_in;

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      mul_en = 1'b0;
      unique case (state_ff)
         S_MUL_F: begin
            op_a   = 32'(arg_ff);
            op_b   = HALF_TURN_PER_STEP;
            mul_en = 1'b1;
         end
         S_MUL_X: begin
            op_a   = g_ff;
            op_b   = PI_Q30;
            mul_en = 1'b1;
         end
         S_MUL_X2: begin
            op_a   = prod_ff[63:32];
            op_b   = prod_ff[63:32];
            mul_en = 1'b1;
         end
         S_MUL_T: begin
            op_a   = (term_ff == TERM_W'(3)) ? x_ff : x2_ff;
            op_b   = {1'b0, t_ff};
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = {32'd0, op_a} * {32'd0, op_b};

   // Fold the half-turn fraction onto the first quarter turn.
   assign g_in = (prod_ff[31:0] > FOLD_POINT) ? (~prod_ff[31:0] + 32'd1) : prod_ff[31:0];

   // Restoring division by a small constant, a few quotient bits a cycle.
   always_comb begin
      logic [DIV_W:0] trial;
      divisor = term_divisor(term_ff);
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      for (int j = 0; j < DIV_STEPS; j++) begin
         trial = {rem_in, dq_in[31]};
         dq_in = {dq_in[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in   = DIV_W'(trial - {1'b0, divisor});
            dq_in[0] = 1'b1;
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
      end
   end

   // Clamp at one, then keep the top fraction bits.
   always_comb begin
      r_val  = prod_ff[61:30];
      mag_in = (r_val[31:30] != 2'b00) ? '1 : r_val[29 -: SINE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_en) begin
            prod_ff <= prod_in;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (sine_req.start) begin
                  arg_ff   <= sine_req.arg;
                  state_ff <= S_MUL_F;
               end
            end
            S_MUL_F: begin
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               g_ff     <= g_in;
               state_ff <= S_MUL_X;
            end
            S_MUL_X: begin
               state_ff <= S_MUL_X2;
            end
            S_MUL_X2: begin
               x_ff     <= prod_ff[63:32];
               term_ff  <= '0;
               state_ff <= S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
               dq_ff  <= prod_ff[61:30];
               rem_ff <= '0;
               cnt_ff <= '0;
               if (term_ff == '0) begin
                  x2_ff <= prod_ff[61:30];
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               dq_ff  <= dq_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
                  state_ff <= S_SUB;
               end
            end
            S_SUB: begin
               t_ff     <= 31'(ONE_Q30 - dq_ff);
               state_ff <= S_MUL_T;
            end
            S_MUL_T: begin
               if (term_ff == TERM_W'(3)) begin
                  state_ff <= S_FINISH;
               end else begin
                  term_ff  <= term_ff + 1'b1;
                  state_ff <= S_DIV_LOAD;
               end
            end
            S_FINISH: begin
               mag_ff   <= mag_in;
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign sine_rsp.done = done_ff;
   assign sine_rsp.mag  = mag_ff;

endmodule

// ===== hw/rtl/lsp_back.sv =====
// Back end: LED table, frame sequencing and the two-stage pixel pipeline.
`timescale 1ns / 1ps

module lsp_back import lsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_rd_type         queue_rd,
   output logic                 queue_pop,
   output sine_req_type         sine_req,
   input  sine_rsp_type         sine_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [LED_IDX_W-1:0] rsp_index,
   output pixel_type            rsp_pixel,
   output logic                 rsp_last
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_SINE_GO,
      B_SINE_WAIT,
      B_EMIT
   } back_state_type;

   back_state_type       state_ff;
   logic [PHASE_W-1:0]   phase_ff;
   logic [15:0]          elapsed_ff;
   logic [RATE_W-1:0]    k_ff;
   logic [LED_IDX_W-1:0] led_ff;
   logic [SINE_BITS-1:0] s_ff [NUM_RATES];

   pixel_type            colour_ff [NUM_LEDS];
   logic                 pulse_ff  [NUM_LEDS];
   logic [RATE_W-1:0]    rate_ff   [NUM_LEDS];
   logic [31:0]          time_ff   [NUM_LEDS];

   logic                 p1_valid_ff;
   logic [LED_IDX_W-1:0] p1_index_ff;
   pixel_type            p1_colour_ff;
   logic [SCALE_W-1:0]   p1_scale_ff;

   logic                 rsp_valid_ff;
   logic [LED_IDX_W-1:0] rsp_index_ff;
   pixel_type            rsp_pixel_ff;
   logic                 rsp_last_ff;

   logic [PHASE_W-1:0]   phase_next;
   logic [PHASE_W-1:0]   phase_in;
   logic                 advance;
   logic                 issue;
   logic                 set_write;
   logic [31:0]          time_cur;
   logic [31:0]          time_in;
   logic [SCALE_W-1:0]   scale_in;
   pixel_type            pixel_in;

   function automatic logic [7:0] scale_channel(input logic [7:0] c,
                                                input logic [SCALE_W-1:0] s);
      logic [7+SCALE_W:0] p;
      p = {{SCALE_W{1'b0}}, c} * {8'd0, s};
      return p[SINE_BITS +: 8];
   endfunction

   assign queue_pop = (state_ff == B_IDLE) && queue_rd.valid;
   assign set_write = queue_pop && (queue_rd.cmd.kind == CMD_SET);
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign issue     = (state_ff == B_EMIT) && advance;

   assign phase_next = phase_ff + 1'b1;
   assign phase_in   = (phase_next == PHASE_W'(PHASE_WRAP)) ? '0 : phase_next;

   assign sine_req.start = (state_ff == B_SINE_GO);
   assign sine_req.arg   = ARG_W'(phase_ff) << k_ff;

   // Count the timer down (saturating) and choose the channel scale.
   always_comb begin
      time_cur = time_ff[led_ff];
      time_in  = (time_cur > {16'd0, elapsed_ff}) ? (time_cur - {16'd0, elapsed_ff}) : '0;
      if (time_in == '0) begin
         scale_in = '0;
      end else if (pulse_ff[led_ff]) begin
         scale_in = {1'b0, s_ff[rate_ff[led_ff]]};
      end else begin
         scale_in = SCALE_W'(1) << SINE_BITS;
      end
      pixel_in.red   = scale_channel(p1_colour_ff.red,   p1_scale_ff);
      pixel_in.green = scale_channel(p1_colour_ff.green, p1_scale_ff);
      pixel_in.blue  = scale_channel(p1_colour_ff.blue,  p1_scale_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         phase_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (queue_pop && (queue_rd.cmd.kind == CMD_FRAME)) begin
                  phase_ff   <= phase_in;
                  elapsed_ff <= queue_rd.cmd.span[15:0];
                  k_ff       <= '0;
                  state_ff   <= B_SINE_GO;
               end
            end
            B_SINE_GO: begin
               state_ff <= B_SINE_WAIT;
            end
            B_SINE_WAIT: begin
               if (sine_rsp.done) begin
                  s_ff[k_ff] <= sine_rsp.mag;
                  if (k_ff == RATE_W'(NUM_RATES - 1)) begin
                     led_ff   <= '0;
                     state_ff <= B_EMIT;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= B_SINE_GO;
                  end
               end
            end
            B_EMIT: begin
               if (advance) begin
                  if (led_ff == LED_IDX_W'(NUM_LEDS - 1)) begin
                     state_ff <= B_IDLE;
                  end else begin
                     led_ff <= led_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase

         if (advance) begin
            p1_valid_ff  <= issue;
            p1_index_ff  <= led_ff;
            p1_colour_ff <= colour_ff[led_ff];
            p1_scale_ff  <= scale_in;
            rsp_valid_ff <= p1_valid_ff;
            rsp_index_ff <= p1_index_ff;
            rsp_pixel_ff <= pixel_in;
            rsp_last_ff  <= (p1_index_ff == LED_IDX_W'(NUM_LEDS - 1));
         end
      end
   end

   // Timers decide whether an LED is lit, so they are the only part of the
   // table that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            time_ff[i] <= '0;
         end
      end else if (set_write) begin
         time_ff[queue_rd.cmd.index] <= queue_rd.cmd.span;
      end else if (issue) begin
         time_ff[led_ff] <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (set_write) begin
         colour_ff[queue_rd.cmd.index] <= queue_rd.cmd.colour;
         pulse_ff[queue_rd.cmd.index]  <= queue_rd.cmd.pulse;
         rate_ff[queue_rd.cmd.index]   <= queue_rd.cmd.rate;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== hw/rtl/led_strip_pulse_timer.sv =====
// Top level of the LED strip pulse timer.
`timescale 1ns / 1ps

// The block keeps a table of LED entries (colour, pulse mode, remaining on-time)
// and renders the whole strip on request. Commands arrive on the req_ stream:
// req_tuser low is a set, which writes one entry (a set beyond the table is
// dropped), and req_tuser high is a frame, which advances the pulse phase,
// counts every timer down by the elapsed milliseconds and emits one rsp_
// transaction per LED in index order, with rsp_tlast on the final LED.
// A set emits nothing; it passes the front end's holding register and the
// queue and lands in the table once the back end is idle. A frame first computes
// four sine magnitudes one after another on a shared multiplier with a small
// constant divider, and then streams one LED per cycle through a two-stage
// pipeline as long as the receiver keeps rsp_tready high.
// The front end and a four-entry command queue keep taking commands while the
// back end renders; req_tready drops only when the queue is full.
// When the receiver holds rsp_tready low, the output register holds its
// transaction and the LED walk pauses in place; nothing is lost or repeated.
// Reset clears the phase, the command queue, the pipeline and every timer, so
// all LEDs read as black until they are set.

module led_strip_pulse_timer import lsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] led_index, [13:6] red_in, [21:14] green_in, [29:22] blue_in,
   // [37:30] mode_in, [69:38] hold_ms, [85:70] elapsed_ms, [87:86] zero
   input  logic [87:0] req_tdata,
   // [0] command
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] pixel_index, [13:6] red_out, [21:14] green_out, [29:22] blue_out,
   // [31:30] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   pixel_type            req_colour;
   queue_wr_type         queue_wr;
   queue_rd_type         queue_rd;
   logic                 queue_full;
   logic                 queue_pop;
   sine_req_type         sine_req;
   sine_rsp_type         sine_rsp;
   logic [LED_IDX_W-1:0] rsp_index;
   pixel_type            rsp_pixel;

   assign req_colour.red   = req_tdata[13:6];
   assign req_colour.green = req_tdata[21:14];
   assign req_colour.blue  = req_tdata[29:22];

   lsp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_command    (req_tuser),
      .req_led_index  (req_tdata[5:0]),
      .req_colour     (req_colour),
      .req_mode       (req_tdata[37:30]),
      .req_hold_ms    (req_tdata[69:38]),
      .req_elapsed_ms (req_tdata[85:70]),
      .queue_full     (queue_full),
      .queue_wr       (queue_wr)
   );

   lsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_pop  (queue_pop),
      .queue_rd   (queue_rd)
   );

   lsp_sine u_sine (
      .clock    (clock),
      .reset    (reset),
      .sine_req (sine_req),
      .sine_rsp (sine_rsp)
   );

   lsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_rd  (queue_rd),
      .queue_pop (queue_pop),
      .sine_req  (sine_req),
      .sine_rsp  (sine_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_index),
      .rsp_pixel (rsp_pixel),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_pixel.blue, rsp_pixel.green, rsp_pixel.red,
                       6'(rsp_index)};

endmodule

// ===== hw/rtl/lsp_checker.sv =====
// Port-level checker for the LED strip pulse timer, bound to the top level.
`timescale 1ns / 1ps
`include "led_strip_pulse_timer_assert.svh"

module lsp_checker import lsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [5:0] exp_index_ff;

   // Expected LED position of the next result, followed from the port alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_index_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         exp_index_ff <= rsp_tlast ? 6'd0 : exp_index_ff + 6'd1;
      end
   end

   `LSP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")
   `LSP_ASSERT_IMPL(a_rsp_order, rsp_tvalid, rsp_tdata[5:0] == exp_index_ff, "result out of LED order")
   `LSP_ASSERT_IMPL(a_rsp_last, rsp_tvalid, rsp_tlast == (rsp_tdata[5:0] == 6'(NUM_LEDS - 1)), "frame end mismatch")

endmodule

bind led_strip_pulse_timer lsp_checker u_lsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
